[hdl/assert_macros.svh]
// assertion macros used by the stack controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[hdl/bstk_pkg.sv]
// shared types, op codes and status codes for the bounded stack
package bstk_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

    typedef logic [2:0]         op_t;
    typedef logic [1:0]         status_t;
    typedef logic signed [31:0] word_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ADDR_W-1:0]  addr_t;

    localparam op_t OP_PUSH    = 3'd0;
    localparam op_t OP_POP     = 3'd1;
    localparam op_t OP_PEEK    = 3'd2;
    localparam op_t OP_REVERSE = 3'd3;
    localparam op_t OP_SORT    = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef struct packed {
        logic apply;
        logic sort_step;
        logic sort_odd;
        logic load_result;
    } dp_cmd_t;

    typedef struct packed {
        logic   starts_sort;
        count_t count;
    } dp_stat_t;

endpackage

[hdl/bstk_datapath.sv]
// stack storage, op execution, transposition sort network and result registers
module bstk_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  bstk_pkg::dp_cmd_t cmd,
    input  bstk_pkg::op_t     op,
    input  bstk_pkg::word_t   push_value,
    output bstk_pkg::dp_stat_t stat,
    output bstk_pkg::status_t status,
    output bstk_pkg::word_t   top_value,
    output bstk_pkg::count_t  entry_count
);
    import bstk_pkg::*;

    word_t   entries_reg [STACK_DEPTH];
    word_t   entries_next [STACK_DEPTH];
    count_t  count_reg;
    count_t  count_next;
    status_t pend_status_reg;
    status_t pend_status_next;
    status_t status_reg;
    word_t   top_reg;
    count_t  cnt_out_reg;
    logic    empty;
    logic    full;
    addr_t   top_idx;
    word_t   top_word;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == COUNT_W'(STACK_DEPTH));
    assign top_idx  = ADDR_W'(count_reg - COUNT_W'(1));
    assign top_word = empty ? '0 : entries_reg[top_idx];

    assign stat.starts_sort = (op == OP_SORT) && !empty;
    assign stat.count       = count_reg;

    always_comb
    begin
        addr_t rev_idx;
        entries_next     = entries_reg;
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        rev_idx          = '0;
        if (cmd.apply)
        begin
            pend_status_next = ST_OK;
            if (op == OP_PUSH)
            begin
                if (full)
                begin
                    pend_status_next = ST_FULL;
                end
                else
                begin
                    entries_next[count_reg[ADDR_W-1:0]] = push_value;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            else if (empty)
            begin
                pend_status_next = ST_EMPTY;
            end
            else
            begin
                case (op)
                    OP_POP:
                    begin
                        count_next = count_reg - COUNT_W'(1);
                    end
                    OP_REVERSE:
                    begin
                        for (int i = 0; i < STACK_DEPTH; i++)
                        begin
                            rev_idx = ADDR_W'(count_reg - COUNT_W'(1) - COUNT_W'(i));
                            if (COUNT_W'(i) < count_reg)
                            begin
                                entries_next[i] = entries_reg[rev_idx];
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (cmd.sort_step)
        begin
            // bottom stays largest: swap a pair when the upper word is greater
            for (int i = 0; i < STACK_DEPTH - 1; i++)
            begin
                if ((i[0] == cmd.sort_odd) && (COUNT_W'(i + 1) < count_reg)
                    && (entries_reg[i + 1] > entries_reg[i]))
                begin
                    entries_next[i]     = entries_reg[i + 1];
                    entries_next[i + 1] = entries_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            pend_status_reg <= ST_OK;
        end
        else
        begin
            count_reg       <= count_next;
            pend_status_reg <= pend_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            status_reg  <= pend_status_reg;
            top_reg     <= top_word;
            cnt_out_reg <= count_reg;
        end
    end

    assign status      = status_reg;
    assign top_value   = top_reg;
    assign entry_count = cnt_out_reg;

endmodule

[hdl/bstk_controller.sv]
// controller sequencing op execution, sort phases and result hand-off
module bstk_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  bstk_pkg::dp_stat_t stat,
    output bstk_pkg::dp_cmd_t  cmd
);
    import bstk_pkg::*;

`include "assert_macros.svh"

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SORT   = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    count_t     phase_reg;
    count_t     phase_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       last_phase;

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign last_phase = (phase_reg == stat.count - COUNT_W'(1));

    assign cmd.apply       = accept;
    assign cmd.sort_step   = (state_reg == S_SORT);
    assign cmd.sort_odd    = phase_reg[0];
    assign cmd.load_result = (state_reg == S_RESULT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                phase_next = '0;
                if (accept)
                begin
                    state_next = stat.starts_sort ? S_SORT : S_RESULT;
                end
            end
            S_SORT:
            begin
                phase_next = phase_reg + COUNT_W'(1);
                if (last_phase)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (cmd.load_result)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.load_result || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_PROP(a_accept_leaves_idle, clk, rst_n, accept |=> (state_reg != S_IDLE))
    `ASSERT_PROP(a_sort_exits_to_result, clk, rst_n,
        (state_reg == S_SORT) |=> (state_reg == S_SORT || state_reg == S_RESULT))
    `ASSERT_PROP(a_phase_in_range, clk, rst_n, (state_reg == S_SORT) |-> (phase_reg < stat.count))
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, cmd.load_result && out_valid_reg && out_stall)

endmodule

[hdl/bounded_stack_with_reverse_sort.sv]
// top level of the bounded stack with reverse and sort
//
//  channel | handshake         | payload
//  --------+-------------------+-----------------------------------
//  in      | in_valid/in_stall | op, push_value
//  out     | out_valid/out_stall | status, top_value, entry_count
//
// push, pop, peek, reverse and empty-stack requests pass through the result state; in_stall holds new items until then
// sort runs odd-even transposition phases, one phase per cycle, before the result state
// reverse is a parallel remap of the register-file entries
// reset clears the fill count and control; stack words are not cleared
// a new item is taken while the previous result waits in the output register
module bounded_stack_with_reverse_sort (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bstk_pkg::op_t     op,
    input  bstk_pkg::word_t   push_value,
    output logic              out_valid,
    input  logic              out_stall,
    output bstk_pkg::status_t status,
    output bstk_pkg::word_t   top_value,
    output bstk_pkg::count_t  entry_count
);
    import bstk_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bstk_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bstk_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op          (op),
        .push_value  (push_value),
        .stat        (stat),
        .status      (status),
        .top_value   (top_value),
        .entry_count (entry_count)
    );

endmodule
